>>> rtl/core/tcb_pkg.sv
// shared types and constants of the text console buffer
// holds state, sweep and access-mode codes plus field widths
// no dependencies
package tcb_pkg;

   localparam int COLUMNS_DEF = 64;
   localparam int LINES_DEF   = 32;

   localparam int MODE_W  = 3;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 8;
   localparam int COL_X_W = 6;
   localparam int ROW_Y_W = 5;

   localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE    = 3'd0,
      MODE_NEWLINE  = 3'd1,
      MODE_CLEAR    = 3'd2,
      MODE_PUT      = 3'd3,
      MODE_READ     = 3'd4,
      MODE_CURSOR   = 3'd5,
      MODE_COLOR    = 3'd6,
      MODE_COLOR_AT = 3'd7
   } tcb_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SWEEP,
      ST_DONE
   } tcb_state_type;

   typedef enum logic [1:0] {
      SW_INIT,
      SW_CLEAR,
      SW_SCROLL
   } tcb_sweep_type;

endpackage

>>> rtl/core/text_console_buffer_core.sv
// Text-mode console buffer: LINES x COLUMNS character grid, one color per row, a cursor.
// req_* carries one access word (mode in tuser), rsp_* returns read character and cursor,
// csr_* writes the scroll fill color. One access is worked on at a time.
// An accepted access passes the EXEC state, a read also the READ state, and then DONE,
// which registers the result. Clear, and a write or newline that leaves the last row
// (scroll), sweep the whole grid memory in the SWEEP state, one cell per cycle; the sweep
// length is set by the single write port of the grid ram. A new access can be taken
// while the previous result still waits in the output register; with the receiver
// stalled, the next finished result holds inside until the output register frees.
// After reset the grid and row colors are cleared to zero by the same sweep;
// req_tready stays low until it ends. Configuration writes are taken in every cycle
// and must only change between accesses.
// Depends on tcb_pkg, tcb_ram and tcb_ctrl.
module text_console_buffer_core #(
   parameter int COLUMNS = tcb_pkg::COLUMNS_DEF,
   parameter int LINES   = tcb_pkg::LINES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // char_code, color, col_x, row_y
   input  logic [2:0]  req_tuser,  // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // read_char, cursor_col, cursor_row
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data    // scroll_fill_color
);

   localparam int CW = $clog2(COLUMNS);
   localparam int RW = $clog2(LINES);
   localparam int AW = CW + RW;

   logic [tcb_pkg::COLOR_W-1:0] fill_color_ff, fill_color_in;

   logic                        grid_wr_en;
   logic [AW-1:0]               grid_wr_addr;
   logic [tcb_pkg::CHAR_W-1:0]  grid_wr_data;
   logic [AW-1:0]               grid_rd_addr;
   logic [tcb_pkg::CHAR_W-1:0]  grid_rd_data;
   logic                        color_wr_en;
   logic [RW-1:0]               color_wr_addr;
   logic [tcb_pkg::COLOR_W-1:0] color_wr_data;
   logic [RW-1:0]               color_rd_addr;
   logic [tcb_pkg::COLOR_W-1:0] color_rd_data;

   logic [tcb_pkg::CHAR_W-1:0]  rsp_read_char;
   logic [tcb_pkg::COL_X_W-1:0] rsp_cursor_col;
   logic [tcb_pkg::ROW_Y_W-1:0] rsp_cursor_row;

   assign csr_ready     = 1'b1;
   assign fill_color_in = (csr_valid && csr_ready) ? csr_data : fill_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_color_ff <= '0;
      end else begin
         fill_color_ff <= fill_color_in;
      end
   end

   tcb_ctrl #(
      .COLUMNS (COLUMNS),
      .LINES   (LINES)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_mode       (req_tuser),
      .req_char_code  (req_tdata[7:0]),
      .req_color      (req_tdata[15:8]),
      .req_col_x      (req_tdata[21:16]),
      .req_row_y      (req_tdata[26:22]),
      .fill_color     (fill_color_ff),
      .grid_wr_en     (grid_wr_en),
      .grid_wr_addr   (grid_wr_addr),
      .grid_wr_data   (grid_wr_data),
      .grid_rd_addr   (grid_rd_addr),
      .grid_rd_data   (grid_rd_data),
      .color_wr_en    (color_wr_en),
      .color_wr_addr  (color_wr_addr),
      .color_wr_data  (color_wr_data),
      .color_rd_addr  (color_rd_addr),
      .color_rd_data  (color_rd_data),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_read_char  (rsp_read_char),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row)
   );

   tcb_ram #(
      .WIDTH (tcb_pkg::CHAR_W),
      .DEPTH (LINES * (2 ** CW))
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (grid_wr_en),
      .wr_addr (grid_wr_addr),
      .wr_data (grid_wr_data),
      .rd_addr (grid_rd_addr),
      .rd_data (grid_rd_data)
   );

   tcb_ram #(
      .WIDTH (tcb_pkg::COLOR_W),
      .DEPTH (LINES)
   ) u_color_ram (
      .clock   (clock),
      .wr_en   (color_wr_en),
      .wr_addr (color_wr_addr),
      .wr_data (color_wr_data),
      .rd_addr (color_rd_addr),
      .rd_data (color_rd_data)
   );

   assign rsp_tdata = {5'b0, rsp_cursor_row, rsp_cursor_col, rsp_read_char};

`ifndef SYNTH
   a_reset_clears_first: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("access accepted right after reset, before the clearing sweep");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second access accepted while one is in flight");
`endif

endmodule

>>> rtl/core/tcb_ram.sv
// simple dual-port synchronous ram, one write and one registered read per cycle
// used for the character grid and the row colors
// no dependencies
module tcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/tcb_ctrl.sv
// access sequencer of the text console buffer: cursor, sweep counter, result register
// drives the grid and row color rams; depends on tcb_pkg
module tcb_ctrl #(
   parameter int COLUMNS = tcb_pkg::COLUMNS_DEF,
   parameter int LINES   = tcb_pkg::LINES_DEF,
   localparam int CW = $clog2(COLUMNS),
   localparam int RW = $clog2(LINES),
   localparam int AW = CW + RW
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [tcb_pkg::MODE_W-1:0]   req_mode,
   input  logic [tcb_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tcb_pkg::COLOR_W-1:0]  req_color,
   input  logic [tcb_pkg::COL_X_W-1:0]  req_col_x,
   input  logic [tcb_pkg::ROW_Y_W-1:0]  req_row_y,
   input  logic [tcb_pkg::COLOR_W-1:0]  fill_color,
   output logic                         grid_wr_en,
   output logic [AW-1:0]                grid_wr_addr,
   output logic [tcb_pkg::CHAR_W-1:0]   grid_wr_data,
   output logic [AW-1:0]                grid_rd_addr,
   input  logic [tcb_pkg::CHAR_W-1:0]   grid_rd_data,
   output logic                         color_wr_en,
   output logic [RW-1:0]                color_wr_addr,
   output logic [tcb_pkg::COLOR_W-1:0]  color_wr_data,
   output logic [RW-1:0]                color_rd_addr,
   input  logic [tcb_pkg::COLOR_W-1:0]  color_rd_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [tcb_pkg::CHAR_W-1:0]   rsp_read_char,
   output logic [tcb_pkg::COL_X_W-1:0]  rsp_cursor_col,
   output logic [tcb_pkg::ROW_Y_W-1:0]  rsp_cursor_row
);

   localparam int N_CELLS = LINES * (2 ** CW);
   localparam logic [AW:0]   CNT_END  = (AW+1)'(N_CELLS);
   localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] LAST_ROW = RW'(LINES - 1);

   // coordinate reduction tables
   logic [CW-1:0] xmod_tab [2 ** tcb_pkg::COL_X_W];
   logic [RW-1:0] ymod_tab [2 ** tcb_pkg::ROW_Y_W];

   for (genvar i = 0; i < 2 ** tcb_pkg::COL_X_W; i++) begin : g_xmod
      localparam int XM = i % COLUMNS;
      assign xmod_tab[i] = CW'(XM);
   end

   for (genvar i = 0; i < 2 ** tcb_pkg::ROW_Y_W; i++) begin : g_ymod
      localparam int YM = i % LINES;
      assign ymod_tab[i] = RW'(YM);
   end

   tcb_pkg::tcb_state_type state_ff, state_in;
   tcb_pkg::tcb_sweep_type kind_ff, kind_in;
   tcb_pkg::tcb_mode_type  mode_ff, mode_in;

   logic [tcb_pkg::CHAR_W-1:0]  char_ff, char_in;
   logic [tcb_pkg::COLOR_W-1:0] color_ff, color_in;
   logic [CW-1:0]               xm_ff, xm_in;
   logic [RW-1:0]               ym_ff, ym_in;
   logic [CW-1:0]               cur_col_ff, cur_col_in;
   logic [RW-1:0]               cur_row_ff, cur_row_in;
   logic [AW:0]                 cnt_ff, cnt_in;

   logic                        gw_pend_ff, gw_pend_in;
   logic                        gw_copy_ff, gw_copy_in;
   logic [AW-1:0]               gw_addr_ff, gw_addr_in;
   logic [tcb_pkg::CHAR_W-1:0]  gw_data_ff, gw_data_in;
   logic                        cw_pend_ff, cw_pend_in;
   logic                        cw_copy_ff, cw_copy_in;
   logic [RW-1:0]               cw_addr_ff, cw_addr_in;
   logic [tcb_pkg::COLOR_W-1:0] cw_data_ff, cw_data_in;

   logic [tcb_pkg::CHAR_W-1:0]  rd_char_ff, rd_char_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tcb_pkg::CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic [tcb_pkg::COL_X_W-1:0] rsp_col_ff, rsp_col_in;
   logic [tcb_pkg::ROW_Y_W-1:0] rsp_row_ff, rsp_row_in;

   logic          accept;
   logic          next_line;
   logic          at_last_row;
   logic          sweep_end;
   logic          rsp_free;
   logic [RW-1:0] cnt_row;
   logic [CW-1:0] cnt_col;
   logic          cnt_last_row;

   assign accept       = req_valid && (state_ff == tcb_pkg::ST_IDLE);
   assign at_last_row  = (cur_row_ff == LAST_ROW);
   assign next_line    = (mode_ff == tcb_pkg::MODE_NEWLINE) ||
                         ((mode_ff == tcb_pkg::MODE_WRITE) && (cur_col_ff == LAST_COL));
   assign sweep_end    = (cnt_ff == CNT_END);
   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign cnt_row      = cnt_ff[AW-1:CW];
   assign cnt_col      = cnt_ff[CW-1:0];
   assign cnt_last_row = (cnt_row == LAST_ROW);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcb_pkg::ST_IDLE: begin
            if (accept) state_in = tcb_pkg::ST_EXEC;
         end
         tcb_pkg::ST_EXEC: begin
            if (mode_ff == tcb_pkg::MODE_READ) begin
               state_in = tcb_pkg::ST_READ;
            end else if (mode_ff == tcb_pkg::MODE_CLEAR) begin
               state_in = tcb_pkg::ST_SWEEP;
            end else if (next_line && at_last_row) begin
               state_in = tcb_pkg::ST_SWEEP;
            end else begin
               state_in = tcb_pkg::ST_DONE;
            end
         end
         tcb_pkg::ST_READ: begin
            state_in = tcb_pkg::ST_DONE;
         end
         tcb_pkg::ST_SWEEP: begin
            if (sweep_end) begin
               state_in = (kind_ff == tcb_pkg::SW_INIT) ? tcb_pkg::ST_IDLE : tcb_pkg::ST_DONE;
            end
         end
         tcb_pkg::ST_DONE: begin
            if (rsp_free) state_in = tcb_pkg::ST_IDLE;
         end
         default: state_in = tcb_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      mode_in      = mode_ff;
      char_in      = char_ff;
      color_in     = color_ff;
      xm_in        = xm_ff;
      ym_in        = ym_ff;
      kind_in      = kind_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      cnt_in       = cnt_ff;
      rd_char_in   = rd_char_ff;
      gw_pend_in   = 1'b0;
      gw_copy_in   = 1'b0;
      gw_addr_in   = cnt_ff[AW-1:0];
      gw_data_in   = '0;
      cw_pend_in   = 1'b0;
      cw_copy_in   = 1'b0;
      cw_addr_in   = cnt_row;
      cw_data_in   = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;

      grid_wr_en    = 1'b0;
      grid_wr_addr  = gw_addr_ff;
      grid_wr_data  = gw_data_ff;
      grid_rd_addr  = {ym_ff, xm_ff};
      color_wr_en   = 1'b0;
      color_wr_addr = cw_addr_ff;
      color_wr_data = cw_data_ff;
      color_rd_addr = '0;

      unique case (state_ff)
         tcb_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in    = tcb_pkg::tcb_mode_type'(req_mode);
               char_in    = req_char_code;
               color_in   = req_color;
               xm_in      = xmod_tab[req_col_x];
               ym_in      = ymod_tab[req_row_y];
               rd_char_in = '0;
            end
         end
         tcb_pkg::ST_EXEC: begin
            unique case (mode_ff)
               tcb_pkg::MODE_WRITE, tcb_pkg::MODE_NEWLINE: begin
                  if (mode_ff == tcb_pkg::MODE_WRITE) begin
                     grid_wr_en   = 1'b1;
                     grid_wr_addr = {cur_row_ff, cur_col_ff};
                     grid_wr_data = char_ff;
                  end
                  if (next_line) begin
                     cur_col_in = '0;
                     if (at_last_row) begin
                        kind_in = tcb_pkg::SW_SCROLL;
                        cnt_in  = '0;
                     end else begin
                        cur_row_in = cur_row_ff + RW'(1);
                     end
                  end else begin
                     cur_col_in = cur_col_ff + CW'(1);
                  end
               end
               tcb_pkg::MODE_CLEAR: begin
                  cur_col_in = '0;
                  cur_row_in = '0;
                  kind_in    = tcb_pkg::SW_CLEAR;
                  cnt_in     = '0;
               end
               tcb_pkg::MODE_PUT: begin
                  grid_wr_en   = 1'b1;
                  grid_wr_addr = {ym_ff, xm_ff};
                  grid_wr_data = char_ff;
               end
               tcb_pkg::MODE_READ: begin
                  grid_rd_addr = {ym_ff, xm_ff};
               end
               tcb_pkg::MODE_CURSOR: begin
                  cur_col_in = xm_ff;
                  cur_row_in = ym_ff;
               end
               tcb_pkg::MODE_COLOR: begin
                  color_wr_en   = 1'b1;
                  color_wr_addr = cur_row_ff;
                  color_wr_data = color_ff;
               end
               tcb_pkg::MODE_COLOR_AT: begin
                  color_wr_en   = 1'b1;
                  color_wr_addr = ym_ff;
                  color_wr_data = color_ff;
               end
            endcase
         end
         tcb_pkg::ST_READ: begin
            rd_char_in = grid_rd_data;
         end
         tcb_pkg::ST_SWEEP: begin
            // read one row ahead, write the cell in the cycle after the read
            if (!sweep_end) begin
               cnt_in     = cnt_ff + (AW+1)'(1);
               gw_pend_in = 1'b1;
               gw_addr_in = cnt_ff[AW-1:0];
               if (kind_ff == tcb_pkg::SW_SCROLL) begin
                  gw_copy_in = !cnt_last_row;
                  gw_data_in = tcb_pkg::BLANK_CHAR;
                  if (!cnt_last_row) begin
                     grid_rd_addr = {cnt_row + RW'(1), cnt_col};
                  end
               end else if (kind_ff == tcb_pkg::SW_CLEAR) begin
                  gw_data_in = char_ff;
               end
               if (cnt_col == '0) begin
                  cw_pend_in = 1'b1;
                  cw_addr_in = cnt_row;
                  if (kind_ff == tcb_pkg::SW_SCROLL) begin
                     cw_copy_in = !cnt_last_row;
                     cw_data_in = fill_color;
                     if (!cnt_last_row) begin
                        color_rd_addr = cnt_row + RW'(1);
                     end
                  end else if (kind_ff == tcb_pkg::SW_CLEAR) begin
                     cw_data_in = color_ff;
                  end
               end
            end
         end
         tcb_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = rd_char_ff;
               rsp_col_in   = tcb_pkg::COL_X_W'(cur_col_ff);
               rsp_row_in   = tcb_pkg::ROW_Y_W'(cur_row_ff);
            end
         end
         default: begin
         end
      endcase

      // delayed sweep writes
      if (gw_pend_ff) begin
         grid_wr_en   = 1'b1;
         grid_wr_addr = gw_addr_ff;
         grid_wr_data = gw_copy_ff ? grid_rd_data : gw_data_ff;
      end
      if (cw_pend_ff) begin
         color_wr_en   = 1'b1;
         color_wr_addr = cw_addr_ff;
         color_wr_data = cw_copy_ff ? color_rd_data : cw_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcb_pkg::ST_SWEEP;
         kind_ff      <= tcb_pkg::SW_INIT;
         cnt_ff       <= '0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         gw_pend_ff   <= 1'b0;
         cw_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         cnt_ff       <= cnt_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         gw_pend_ff   <= gw_pend_in;
         cw_pend_ff   <= cw_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      char_ff     <= char_in;
      color_ff    <= color_in;
      xm_ff       <= xm_in;
      ym_ff       <= ym_in;
      rd_char_ff  <= rd_char_in;
      gw_copy_ff  <= gw_copy_in;
      gw_addr_ff  <= gw_addr_in;
      gw_data_ff  <= gw_data_in;
      cw_copy_ff  <= cw_copy_in;
      cw_addr_ff  <= cw_addr_in;
      cw_data_ff  <= cw_data_in;
      rsp_char_ff <= rsp_char_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
   end

   assign req_ready      = (state_ff == tcb_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_char  = rsp_char_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;

endmodule

>>> tb/sv/console_checker.sv
`timescale 1ns / 100ps
// watches the access, result and fill color channels of text_console_buffer_core,
// keeps its own copy of the screen, the cursor and the fill color, and checks every result
// depends on tcb_pkg
module console_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_data,
   output int          mismatch_count,
   output int          outstanding
);

   typedef struct packed {
      logic [tcb_pkg::ROW_Y_W-1:0] cursor_row;
      logic [tcb_pkg::COL_X_W-1:0] cursor_col;
      logic [tcb_pkg::CHAR_W-1:0]  read_char;
   } console_reply_type;

   logic [tcb_pkg::CHAR_W-1:0]  screen [tcb_pkg::LINES_DEF][tcb_pkg::COLUMNS_DEF];
   logic [tcb_pkg::COLOR_W-1:0] row_tint [tcb_pkg::LINES_DEF];
   logic [tcb_pkg::COL_X_W-1:0] cur_col;
   logic [tcb_pkg::ROW_Y_W-1:0] cur_row;
   logic [tcb_pkg::COLOR_W-1:0] fill_color;

   console_reply_type reply_queue [$];

   function automatic void wipe_screen(input logic [tcb_pkg::CHAR_W-1:0] ch,
                                       input logic [tcb_pkg::COLOR_W-1:0] color);
      for (int r = 0; r < tcb_pkg::LINES_DEF; r++) begin
         row_tint[r] = color;
         for (int c = 0; c < tcb_pkg::COLUMNS_DEF; c++) begin
            screen[r][c] = ch;
         end
      end
      cur_col = '0;
      cur_row = '0;
   endfunction

   function automatic void scroll_screen();
      for (int r = 0; r < tcb_pkg::LINES_DEF - 1; r++) begin
         screen[r]   = screen[r+1];
         row_tint[r] = row_tint[r+1];
      end
      for (int c = 0; c < tcb_pkg::COLUMNS_DEF; c++) begin
         screen[tcb_pkg::LINES_DEF-1][c] = tcb_pkg::BLANK_CHAR;
      end
      row_tint[tcb_pkg::LINES_DEF-1] = fill_color;
   endfunction

   function automatic void advance_row();
      cur_col = '0;
      if (cur_row == tcb_pkg::LINES_DEF - 1) begin
         scroll_screen();
      end else begin
         cur_row = cur_row + 1'b1;
      end
   endfunction

   function automatic console_reply_type apply_access(
         input tcb_pkg::tcb_mode_type mode,
         input logic [tcb_pkg::CHAR_W-1:0] ch,
         input logic [tcb_pkg::COLOR_W-1:0] color,
         input logic [tcb_pkg::COL_X_W-1:0] x,
         input logic [tcb_pkg::ROW_Y_W-1:0] y);
      console_reply_type reply;
      reply.read_char = '0;
      case (mode)
         tcb_pkg::MODE_WRITE: begin
            screen[cur_row][cur_col] = ch;
            if (cur_col == tcb_pkg::COLUMNS_DEF - 1) begin
               advance_row();
            end else begin
               cur_col = cur_col + 1'b1;
            end
         end
         tcb_pkg::MODE_NEWLINE: advance_row();
         tcb_pkg::MODE_CLEAR: wipe_screen(ch, color);
         tcb_pkg::MODE_PUT: screen[y][x] = ch;
         tcb_pkg::MODE_READ: reply.read_char = screen[y][x];
         tcb_pkg::MODE_CURSOR: begin
            cur_col = x;
            cur_row = y;
         end
         tcb_pkg::MODE_COLOR: row_tint[cur_row] = color;
         default: row_tint[y] = color;
      endcase
      reply.cursor_col = cur_col;
      reply.cursor_row = cur_row;
      return reply;
   endfunction

   task automatic note_mismatch(input string what, input int want_v, input int got_v);
      if (mismatch_count < 10) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, what, want_v,
                  got_v);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      console_reply_type want;
      console_reply_type got;
      if (reset) begin
         wipe_screen('0, '0);
         fill_color = '0;
         reply_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            fill_color = csr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[18:0];
            if (reply_queue.size() == 0) begin
               note_mismatch("unexpected result word", 0, int'(got));
            end else begin
               want = reply_queue.pop_front();
               if (got.read_char != want.read_char) begin
                  note_mismatch("read_char", int'(want.read_char), int'(got.read_char));
               end
               if (got.cursor_col != want.cursor_col) begin
                  note_mismatch("cursor_col", int'(want.cursor_col), int'(got.cursor_col));
               end
               if (got.cursor_row != want.cursor_row) begin
                  note_mismatch("cursor_row", int'(want.cursor_row), int'(got.cursor_row));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            reply_queue.push_back(apply_access(tcb_pkg::tcb_mode_type'(req_tuser),
                                               req_tdata[7:0], req_tdata[15:8],
                                               req_tdata[21:16], req_tdata[26:22]));
         end
      end
      outstanding = reply_queue.size();
   end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// top of the text console buffer testbench: clock, reset, access and fill color stimulus,
// random receiver stalls and the verdict; checking is done in console_checker
// depends on tcb_pkg, text_console_buffer_core and console_checker
module testbench;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // char_code, color, col_x, row_y
   logic [2:0]  req_tuser;   // mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // read_char, cursor_col, cursor_row
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;    // scroll_fill_color

   int mismatch_count;
   int outstanding;

   int burst_left;
   bit backlog_wanted;
   bit backlog_done;
   int backlog_cycles;
   int hold_left;
   int eager_left;
   logic [tcb_pkg::COL_X_W-1:0] last_put_x;
   logic [tcb_pkg::ROW_Y_W-1:0] last_put_y;

   text_console_buffer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   console_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
   end

   always #2 clock = ~clock;

   initial begin
      #12_000_000;
      $display("testbench NOT OK");
      $finish;
   end

   // receiver: random stalls, ready stretches, and one long hold-off to back the block up
   initial begin
      rsp_tready     = 1'b0;
      hold_left      = 0;
      eager_left     = 0;
      backlog_cycles = 0;
      backlog_done   = 1'b0;
      forever begin
         @(negedge clock);
         if (backlog_wanted && !backlog_done) begin
            rsp_tready <= 1'b0;
            backlog_cycles++;
            if (backlog_cycles >= 400) begin
               backlog_done = 1'b1;
            end
         end else if (eager_left > 0) begin
            rsp_tready <= 1'b1;
            eager_left--;
         end else if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 3) begin
               eager_left = $urandom_range(50, 200);
               rsp_tready <= 1'b1;
            end else if (r < 60) begin
               rsp_tready <= 1'b1;
            end else if (r < 95) begin
               rsp_tready <= 1'b0;
               hold_left = $urandom_range(0, 2);
            end else begin
               rsp_tready <= 1'b0;
               hold_left = $urandom_range(15, 60);
            end
         end
      end
   end

   task automatic write_fill_color(input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_access(input tcb_pkg::tcb_mode_type mode,
                              input logic [tcb_pkg::CHAR_W-1:0] ch,
                              input logic [tcb_pkg::COLOR_W-1:0] color,
                              input logic [tcb_pkg::COL_X_W-1:0] x,
                              input logic [tcb_pkg::ROW_Y_W-1:0] y);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {5'b0, y, x, color, ch};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic sender_gap();
      int r;
      int n;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
         n = 0;
      end else if (r < 95) begin
         n = $urandom_range(1, 3);
      end else begin
         n = $urandom_range(20, 80);
      end
      if ($urandom_range(0, 19) == 0) begin
         burst_left = $urandom_range(10, 30);
      end
      if (n > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic send_random_access();
      int r;
      tcb_pkg::tcb_mode_type mode;
      logic [tcb_pkg::CHAR_W-1:0]  ch;
      logic [tcb_pkg::COLOR_W-1:0] color;
      logic [tcb_pkg::COL_X_W-1:0] x;
      logic [tcb_pkg::ROW_Y_W-1:0] y;
      r     = $urandom_range(0, 99);
      ch    = tcb_pkg::CHAR_W'($urandom_range(0, 255));
      color = tcb_pkg::COLOR_W'($urandom_range(0, 255));
      x     = tcb_pkg::COL_X_W'($urandom_range(0, 63));
      y     = tcb_pkg::ROW_Y_W'($urandom_range(0, 31));
      if (r < 35) begin
         mode = tcb_pkg::MODE_WRITE;
      end else if (r < 45) begin
         mode = tcb_pkg::MODE_NEWLINE;
      end else if (r < 48) begin
         mode = tcb_pkg::MODE_CLEAR;
      end else if (r < 60) begin
         mode = tcb_pkg::MODE_PUT;
      end else if (r < 80) begin
         mode = tcb_pkg::MODE_READ;
      end else if (r < 88) begin
         mode = tcb_pkg::MODE_CURSOR;
      end else if (r < 94) begin
         mode = tcb_pkg::MODE_COLOR;
      end else begin
         mode = tcb_pkg::MODE_COLOR_AT;
      end
      // steer the cursor toward the right edge and the bottom rows to hit wraps and scrolls
      if (mode == tcb_pkg::MODE_CURSOR) begin
         if ($urandom_range(0, 9) < 3) x = tcb_pkg::COL_X_W'($urandom_range(56, 63));
         if ($urandom_range(0, 9) < 3) y = tcb_pkg::ROW_Y_W'($urandom_range(28, 31));
      end
      if (mode == tcb_pkg::MODE_READ && $urandom_range(0, 1) == 1) begin
         x = last_put_x;
         y = last_put_y;
      end
      if (mode == tcb_pkg::MODE_PUT) begin
         last_put_x = x;
         last_put_y = y;
      end
      sender_gap();
      send_access(mode, ch, color, x, y);
   endtask

   task automatic run_random_phase(input int count);
      repeat (count) send_random_access();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (outstanding == 0);
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = tcb_pkg::MODE_WRITE;
      csr_valid      = 1'b0;
      csr_data       = '0;
      burst_left     = 0;
      backlog_wanted = 1'b0;
      last_put_x     = '0;
      last_put_y     = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_fill_color(8'hFF);

      // directed: reset contents, wraps, scrolls, clears, field extremes
      send_access(tcb_pkg::MODE_READ,     8'h00, 8'h00, 6'd0,  5'd0);
      send_access(tcb_pkg::MODE_READ,     8'h00, 8'h00, 6'd63, 5'd31);
      send_access(tcb_pkg::MODE_WRITE,    8'h00, 8'h00, 6'd0,  5'd0);
      send_access(tcb_pkg::MODE_WRITE,    8'hFF, 8'hFF, 6'd63, 5'd31);
      send_access(tcb_pkg::MODE_READ,     8'h00, 8'h00, 6'd0,  5'd0);
      send_access(tcb_pkg::MODE_READ,     8'h00, 8'h00, 6'd1,  5'd0);
      send_access(tcb_pkg::MODE_PUT,      8'hFF, 8'h00, 6'd63, 5'd31);
      send_access(tcb_pkg::MODE_PUT,      8'h5A, 8'h00, 6'd0,  5'd31);
      send_access(tcb_pkg::MODE_READ,     8'h00, 8'h00, 6'd63, 5'd31);
      send_access(tcb_pkg::MODE_CURSOR,   8'h00, 8'h00, 6'd62, 5'd0);
      send_access(tcb_pkg::MODE_WRITE,    8'h41, 8'h00, 6'd0,  5'd0);
      send_access(tcb_pkg::MODE_WRITE,    8'h42, 8'h00, 6'd0,  5'd0);
      send_access(tcb_pkg::MODE_READ,     8'h00, 8'h00, 6'd63, 5'd0);
      send_access(tcb_pkg::MODE_COLOR,    8'h00, 8'hFF, 6'd0,  5'd0);
      send_access(tcb_pkg::MODE_COLOR_AT, 8'h00, 8'h00, 6'd0,  5'd31);
      send_access(tcb_pkg::MODE_NEWLINE,  8'h00, 8'h00, 6'd0,  5'd0);
      send_access(tcb_pkg::MODE_CURSOR,   8'h00, 8'h00, 6'd63, 5'd31);
      send_access(tcb_pkg::MODE_WRITE,    8'h7E, 8'h00, 6'd0,  5'd0);
      send_access(tcb_pkg::MODE_READ,     8'h00, 8'h00, 6'd63, 5'd30);
      send_access(tcb_pkg::MODE_READ,     8'h00, 8'h00, 6'd5,  5'd31);
      send_access(tcb_pkg::MODE_NEWLINE,  8'h00, 8'h00, 6'd0,  5'd0);
      send_access(tcb_pkg::MODE_READ,     8'h00, 8'h00, 6'd63, 5'd29);
      send_access(tcb_pkg::MODE_CLEAR,    8'hFF, 8'hFF, 6'd0,  5'd0);
      send_access(tcb_pkg::MODE_READ,     8'h00, 8'h00, 6'd17, 5'd9);
      send_access(tcb_pkg::MODE_WRITE,    8'h20, 8'h00, 6'd0,  5'd0);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (outstanding == 0);

      write_fill_color(8'h00);
      backlog_wanted = 1'b1;
      burst_left     = 30;
      run_random_phase(89);

      write_fill_color(8'($urandom_range(0, 255)));
      run_random_phase(89);

      write_fill_color(8'hA5);
      run_random_phase(89);

      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
